>>> src/tqv_pkg.sv
// Shared constants, register codes and tables of the torus quad vertex generator.
package tqv_pkg;

  localparam int unsigned MIN_STEPS    = 8;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned PHASE_W      = 24;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned VIDX_W       = 18;

  localparam logic [CFG_IDX_W-1:0] REG_MAJOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MINOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS = 2'd2;

  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BR = 2'd2;
  localparam logic [1:0] CORNER_BL = 2'd3;

  localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;

  function automatic logic signed [24:0] atan_turn(input logic [3:0] k);
    logic signed [24:0] v;
    case (k)
      4'd0:    v = 25'sd2097152;
      4'd1:    v = 25'sd1238021;
      4'd2:    v = 25'sd654136;
      4'd3:    v = 25'sd332050;
      4'd4:    v = 25'sd166669;
      4'd5:    v = 25'sd83416;
      4'd6:    v = 25'sd41718;
      4'd7:    v = 25'sd20860;
      4'd8:    v = 25'sd10430;
      4'd9:    v = 25'sd5215;
      4'd10:   v = 25'sd2608;
      4'd11:   v = 25'sd1304;
      4'd12:   v = 25'sd652;
      4'd13:   v = 25'sd326;
      4'd14:   v = 25'sd163;
      default: v = 25'sd81;
    endcase
    return v;
  endfunction

endpackage

>>> src/tqv_in_if.sv
// Input channel: one quad cell word.
interface tqv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ring_index;
  logic [7:0] segment_index;
  modport source(output valid, ring_index, segment_index, input ready);
  modport sink(input valid, ring_index, segment_index, output ready);
endinterface

>>> src/tqv_out_if.sv
// Result channel: one vertex word.
interface tqv_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [tqv_pkg::VIDX_W-1:0]           vertex_index;
  logic [1:0]                           corner;
  logic signed [17:0]                   pos_x;
  logic signed [17:0]                   pos_y;
  logic signed [17:0]                   pos_z;
  logic signed [15:0]                   norm_x;
  logic signed [15:0]                   norm_y;
  logic signed [15:0]                   norm_z;
  logic                                 bad_index;
  logic                                 last;
  modport source(output valid, vertex_index, corner, pos_x, pos_y, pos_z,
                 norm_x, norm_y, norm_z, bad_index, last, input ready);
  modport sink(input valid, vertex_index, corner, pos_x, pos_y, pos_z,
               norm_x, norm_y, norm_z, bad_index, last, output ready);
endinterface

>>> src/tqv_cfg_if.sv
// Configuration write channel: register index and data word.
interface tqv_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tqv_pkg::CFG_IDX_W-1:0]     index;
  logic [tqv_pkg::CFG_DATA_W-1:0]    data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> src/torus_quad_vertex_generator.sv
// Torus quad vertex generator top level: configuration registers and block wiring.
// Throughput: one vertex per cycle while the output is not stalled, four per cell from the
// back end's corner walk; a cell with an index not below N holds the front end while it reduces the indices modulo N.
// Reset and every step_request write rebuild the trig table, one divide and one CORDIC per
// entry; no cell is accepted meanwhile, configuration writes still are.
// Reset is synchronous, active low, and restores the register reset values.
module torus_quad_vertex_generator #(
  parameter int MAX_STEPS = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  tqv_in_if.sink     in_ch,
  tqv_out_if.source  out_ch,
  tqv_cfg_if.sink    cfg_ch
);
  localparam int AW = $clog2(MAX_STEPS);
  localparam int NW = $clog2(MAX_STEPS+1);
  localparam int EW = 19 + 4*AW;

  logic [15:0]   major_r;
  logic [15:0]   minor_r;
  logic [8:0]    steps_r;
  logic [11:0]   n_wide;
  logic [NW-1:0] n;
  logic          cfg_wr;
  logic          start;
  logic          tbl_busy;

  logic          push, full, pop, head_valid;
  logic [EW-1:0] entry, head;

  logic                 rd_en;
  logic [AW-1:0]        rd_a_addr, rd_b_addr;
  logic signed [15:0]   rd_a_cos, rd_a_sin, rd_b_cos, rd_b_sin;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;
  assign start        = cfg_wr && (cfg_ch.index == tqv_pkg::REG_STEPS);

  always_comb begin
    n_wide = 12'(steps_r);
    if (n_wide < 12'(tqv_pkg::MIN_STEPS)) n_wide = 12'(tqv_pkg::MIN_STEPS);
    if (n_wide > 12'(MAX_STEPS))          n_wide = 12'(MAX_STEPS);
    n = NW'(n_wide);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      major_r <= 16'd256;
      minor_r <= 16'd64;
      steps_r <= 9'd8;
    end else if (cfg_wr) begin
      case (cfg_ch.index)
        tqv_pkg::REG_MAJOR: major_r <= cfg_ch.data;
        tqv_pkg::REG_MINOR: minor_r <= cfg_ch.data;
        tqv_pkg::REG_STEPS: steps_r <= cfg_ch.data[8:0];
        default: begin
        end
      endcase
    end
  end

  tqv_trig_table #(.MAX_STEPS(MAX_STEPS)) u_table (
    .clk(clk), .rst_n(rst_n), .start(start), .n(n), .busy(tbl_busy),
    .rd_en(rd_en), .rd_a_addr(rd_a_addr), .rd_b_addr(rd_b_addr),
    .rd_a_cos(rd_a_cos), .rd_a_sin(rd_a_sin), .rd_b_cos(rd_b_cos), .rd_b_sin(rd_b_sin)
  );

  tqv_front #(.MAX_STEPS(MAX_STEPS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .n(n), .tbl_busy(tbl_busy),
    .full(full), .push(push), .entry(entry)
  );

  tqv_fifo #(.W(EW)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .din(entry), .full(full),
    .pop(pop), .valid(head_valid), .dout(head)
  );

  tqv_back #(.MAX_STEPS(MAX_STEPS)) u_back (
    .clk(clk), .rst_n(rst_n), .head_valid(head_valid), .head(head), .pop(pop),
    .major(major_r), .minor(minor_r), .rd_en(rd_en),
    .rd_a_addr(rd_a_addr), .rd_b_addr(rd_b_addr),
    .rd_a_cos(rd_a_cos), .rd_a_sin(rd_a_sin), .rd_b_cos(rd_b_cos), .rd_b_sin(rd_b_sin),
    .out_ch(out_ch)
  );

endmodule

>>> src/tqv_trig_table.sv
// Cosine/sine table of the N angle steps, built by a serial divider and CORDIC.
module tqv_trig_table #(
  parameter int MAX_STEPS = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [$clog2(MAX_STEPS+1)-1:0]       n,
  output logic                                 busy,
  input  logic                                 rd_en,
  input  logic [$clog2(MAX_STEPS)-1:0]         rd_a_addr,
  input  logic [$clog2(MAX_STEPS)-1:0]         rd_b_addr,
  output logic signed [15:0]                   rd_a_cos,
  output logic signed [15:0]                   rd_a_sin,
  output logic signed [15:0]                   rd_b_cos,
  output logic signed [15:0]                   rd_b_sin
);
  localparam int AW = $clog2(MAX_STEPS);
  localparam int NW = $clog2(MAX_STEPS+1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_CORD  = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  logic [1:0]         state_r;
  logic [AW-1:0]      a_r;
  logic [4:0]         cnt_r;
  logic [NW-1:0]      rem_r;
  logic [23:0]        q_r;
  logic [1:0]         quad_r;
  logic signed [33:0] x_r;
  logic signed [33:0] y_r;
  logic signed [24:0] z_r;

  logic [31:0] mem [MAX_STEPS];
  logic [31:0] rd_a_r;
  logic [31:0] rd_b_r;

  logic [23:0]        half;
  logic               div_bit;
  logic [NW:0]        rem2;
  logic [NW:0]        rem_sub;
  logic               ge;
  logic [NW-1:0]      rem_nxt;
  logic [23:0]        q_fin;
  logic [3:0]         k;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [24:0] at;
  logic signed [33:0] cc;
  logic signed [33:0] ss;
  logic signed [15:0] cos_w;
  logic signed [15:0] sin_w;
  logic               a_last;
  logic [AW-1:0]      a_inc;

  function automatic logic signed [15:0] round_q14(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = (v + 34'sd32768) >>> 16;
    if (t > 34'sd16384) t = 34'sd16384;
    else if (t < -34'sd16384) t = -34'sd16384;
    return t[15:0];
  endfunction

  assign busy    = (state_r != ST_IDLE);
  assign half    = 24'(n >> 1);
  assign div_bit = half[5'd23 - cnt_r];
  assign rem2    = {rem_r, div_bit};
  assign ge      = (rem2 >= {1'b0, n});
  assign rem_sub = rem2 - {1'b0, n};
  assign rem_nxt = ge ? rem_sub[NW-1:0] : rem2[NW-1:0];
  assign q_fin   = {q_r[22:0], ge};

  assign k  = cnt_r[3:0];
  assign dx = y_r >>> k;
  assign dy = x_r >>> k;
  assign at = tqv_pkg::atan_turn(k);

  assign a_last = (12'(a_r) + 12'd1 == 12'(n));
  assign a_inc  = AW'(12'(a_r) + 12'd1);

  always_comb begin
    case (quad_r)
      2'd0:    begin cc = x_r;  ss = y_r;  end
      2'd1:    begin cc = -y_r; ss = x_r;  end
      2'd2:    begin cc = -x_r; ss = -y_r; end
      default: begin cc = y_r;  ss = -x_r; end
    endcase
    cos_w = round_q14(cc);
    sin_w = round_q14(ss);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      state_r <= ST_DIV;
      a_r     <= '0;
      cnt_r   <= '0;
      rem_r   <= '0;
    end else begin
      unique case (state_r)
        ST_DIV: begin
          rem_r <= rem_nxt;
          if (cnt_r == 5'd23) begin
            state_r <= ST_CORD;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        ST_CORD: begin
          if (cnt_r == 5'(tqv_pkg::CORDIC_STEPS - 1)) begin
            state_r <= ST_WRITE;
          end
          cnt_r <= cnt_r + 5'd1;
        end
        ST_WRITE: begin
          cnt_r <= '0;
          if (a_last) begin
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_DIV;
            a_r     <= a_inc;
            rem_r   <= NW'(a_inc);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DIV) begin
      q_r <= q_fin;
      if (cnt_r == 5'd23) begin
        quad_r <= q_fin[23:22];
        z_r    <= $signed({3'b000, q_fin[21:0]});
        x_r    <= tqv_pkg::CORDIC_GAIN_INV;
        y_r    <= '0;
      end
    end else if (state_r == ST_CORD) begin
      if (!z_r[24]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_WRITE) begin
      mem[a_r] <= {cos_w, sin_w};
    end
    if (rd_en) begin
      rd_a_r <= mem[rd_a_addr];
      rd_b_r <= mem[rd_b_addr];
    end
  end

  assign rd_a_cos = rd_a_r[31:16];
  assign rd_a_sin = rd_a_r[15:0];
  assign rd_b_cos = rd_b_r[31:16];
  assign rd_b_sin = rd_b_r[15:0];

endmodule

>>> src/tqv_front.sv
// Front end: accepts cells, reduces indices modulo N, forms the vertex base.
module tqv_front #(
  parameter int MAX_STEPS = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  tqv_in_if.sink                             in_ch,
  input  logic [$clog2(MAX_STEPS+1)-1:0]     n,
  input  logic                               tbl_busy,
  input  logic                               full,
  output logic                               push,
  output logic [19+4*$clog2(MAX_STEPS)-1:0]  entry
);
  localparam int AW = $clog2(MAX_STEPS);
  localparam int NW = $clog2(MAX_STEPS+1);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MOD  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]    state_r;
  logic [2:0]    cnt_r;
  logic [7:0]    i_r;
  logic [7:0]    j_r;
  logic [NW-1:0] ri_r;
  logic [NW-1:0] rj_r;

  logic          acc;
  logic          in_range;
  logic          fast;
  logic [NW:0]   ri2;
  logic [NW:0]   rj2;
  logic [NW-1:0] ri_nxt;
  logic [NW-1:0] rj_nxt;
  logic [7:0]    src_i;
  logic [7:0]    src_j;
  logic [AW-1:0] a0;
  logic [AW-1:0] a1;
  logic [AW-1:0] b0;
  logic [AW-1:0] b1;
  logic [11:0]   a_inc;
  logic [11:0]   b_inc;
  logic [19:0]   cell_lin;
  logic [17:0]   base;
  logic          bad;

  assign in_ch.ready = (state_r == F_IDLE) && !full && !tbl_busy;
  assign acc      = in_ch.valid && in_ch.ready;
  assign in_range = (12'(in_ch.ring_index) < 12'(n)) && (12'(in_ch.segment_index) < 12'(n));
  assign fast     = acc && in_range;

  assign ri2    = {ri_r, i_r[3'd7 - cnt_r]};
  assign rj2    = {rj_r, j_r[3'd7 - cnt_r]};
  assign ri_nxt = (ri2 >= {1'b0, n}) ? NW'(ri2 - {1'b0, n}) : ri2[NW-1:0];
  assign rj_nxt = (rj2 >= {1'b0, n}) ? NW'(rj2 - {1'b0, n}) : rj2[NW-1:0];

  always_comb begin
    if (state_r == F_IDLE) begin
      src_i = in_ch.ring_index;
      src_j = in_ch.segment_index;
      a0    = AW'(in_ch.ring_index);
      b0    = AW'(in_ch.segment_index);
      bad   = 1'b0;
    end else begin
      src_i = i_r;
      src_j = j_r;
      a0    = AW'(ri_r);
      b0    = AW'(rj_r);
      bad   = 1'b1;
    end
    a_inc    = 12'(a0) + 12'd1;
    b_inc    = 12'(b0) + 12'd1;
    a1       = (a_inc == 12'(n)) ? '0 : AW'(a_inc);
    b1       = (b_inc == 12'(n)) ? '0 : AW'(b_inc);
    cell_lin = 20'(src_i) * 20'(n) + 20'(src_j);
    base     = {cell_lin[15:0], 2'b00};
  end

  assign push  = fast || ((state_r == F_PUSH) && !full);
  assign entry = {bad, base, a0, a1, b0, b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (acc && !in_range) begin
            state_r <= F_MOD;
            cnt_r   <= '0;
          end
        end
        F_MOD: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd7) state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!full) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE) begin
      i_r  <= in_ch.ring_index;
      j_r  <= in_ch.segment_index;
      ri_r <= '0;
      rj_r <= '0;
    end else if (state_r == F_MOD) begin
      ri_r <= ri_nxt;
      rj_r <= rj_nxt;
    end
  end

endmodule

>>> src/tqv_fifo.sv
// Two-entry queue between front and back end.
module tqv_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] dout
);
  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   count_r;

  assign full  = (count_r == 2'd2);
  assign valid = (count_r != 2'd0);
  assign dout  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop)      count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

endmodule

>>> src/tqv_back.sv
// Back end: walks the four corners and computes positions and normals.
module tqv_back #(
  parameter int MAX_STEPS = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               head_valid,
  input  logic [19+4*$clog2(MAX_STEPS)-1:0]  head,
  output logic                               pop,
  input  logic [15:0]                        major,
  input  logic [15:0]                        minor,
  output logic                               rd_en,
  output logic [$clog2(MAX_STEPS)-1:0]       rd_a_addr,
  output logic [$clog2(MAX_STEPS)-1:0]       rd_b_addr,
  input  logic signed [15:0]                 rd_a_cos,
  input  logic signed [15:0]                 rd_a_sin,
  input  logic signed [15:0]                 rd_b_cos,
  input  logic signed [15:0]                 rd_b_sin,
  tqv_out_if.source                          out_ch
);
  localparam int AW = $clog2(MAX_STEPS);
  localparam int EW = 19 + 4*AW;

  logic [1:0]  corner_r;
  logic        en;

  logic        bad_h;
  logic [17:0] base_h;
  logic [AW-1:0] a0;
  logic [AW-1:0] a1;
  logic [AW-1:0] b0;
  logic [AW-1:0] b1;

  logic        v1_r, v2_r, v3_r, out_valid_r;
  logic [17:0] idx1_r, idx2_r, idx3_r;
  logic [1:0]  cor1_r, cor2_r, cor3_r;
  logic        bad1_r, bad2_r, bad3_r;

  logic signed [15:0] cu2_r, su2_r, sv2_r, sv3_r;
  logic signed [31:0] nxp2_r, nyp2_r, ring2_r;
  logic signed [32:0] pzp2_r;
  logic signed [47:0] pxp3_r, pyp3_r;
  logic signed [15:0] nx3_r, ny3_r;
  logic signed [17:0] pz3_r;

  logic signed [32:0] rcv;
  logic signed [32:0] ring;
  logic signed [32:0] pzp;
  logic signed [31:0] nx_t;
  logic signed [31:0] ny_t;
  logic signed [32:0] pz_t;

  logic [17:0]        o_idx_r;
  logic [1:0]         o_cor_r;
  logic               o_bad_r;
  logic signed [17:0] o_px_r, o_py_r, o_pz_r;
  logic signed [15:0] o_nx_r, o_ny_r, o_nz_r;

  function automatic logic signed [17:0] round_q9_8(input logic signed [47:0] v);
    logic signed [47:0] t;
    t = (v + 48'sd134217728) >>> 28;
    if (t > 48'sd131071) t = 48'sd131071;
    else if (t < -48'sd131072) t = -48'sd131072;
    return t[17:0];
  endfunction

  assign bad_h  = head[EW-1];
  assign base_h = head[EW-2 -: 18];
  assign a0     = head[4*AW-1 -: AW];
  assign a1     = head[3*AW-1 -: AW];
  assign b0     = head[2*AW-1 -: AW];
  assign b1     = head[AW-1:0];

  assign en        = !out_valid_r || out_ch.ready;
  assign rd_en     = en;
  assign rd_a_addr = (corner_r == tqv_pkg::CORNER_TR || corner_r == tqv_pkg::CORNER_BR) ? a1 : a0;
  assign rd_b_addr = (corner_r == tqv_pkg::CORNER_BR || corner_r == tqv_pkg::CORNER_BL) ? b1 : b0;
  assign pop       = head_valid && en && (corner_r == tqv_pkg::CORNER_BL);

  assign rcv  = $signed({1'b0, minor}) * rd_b_cos;
  assign ring = $signed({3'b000, major, 14'b0}) + rcv;
  assign pzp  = $signed({1'b0, minor}) * rd_b_sin;
  assign nx_t = (nxp2_r + 32'sd8192) >>> 14;
  assign ny_t = (nyp2_r + 32'sd8192) >>> 14;
  assign pz_t = (pzp2_r + 33'sd8192) >>> 14;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_r    <= tqv_pkg::CORNER_TL;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      if (head_valid) corner_r <= corner_r + 2'd1;
      v1_r        <= head_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx1_r <= {base_h[17:2], corner_r};
      cor1_r <= corner_r;
      bad1_r <= bad_h;

      idx2_r  <= idx1_r;
      cor2_r  <= cor1_r;
      bad2_r  <= bad1_r;
      cu2_r   <= rd_a_cos;
      su2_r   <= rd_a_sin;
      sv2_r   <= rd_b_sin;
      nxp2_r  <= rd_b_cos * rd_a_cos;
      nyp2_r  <= rd_b_cos * rd_a_sin;
      ring2_r <= ring[31:0];
      pzp2_r  <= pzp;

      idx3_r <= idx2_r;
      cor3_r <= cor2_r;
      bad3_r <= bad2_r;
      sv3_r  <= sv2_r;
      pxp3_r <= ring2_r * cu2_r;
      pyp3_r <= ring2_r * su2_r;
      nx3_r  <= nx_t[15:0];
      ny3_r  <= ny_t[15:0];
      pz3_r  <= pz_t[17:0];

      o_idx_r <= idx3_r;
      o_cor_r <= cor3_r;
      o_bad_r <= bad3_r;
      o_px_r  <= round_q9_8(pxp3_r);
      o_py_r  <= round_q9_8(pyp3_r);
      o_pz_r  <= pz3_r;
      o_nx_r  <= nx3_r;
      o_ny_r  <= ny3_r;
      o_nz_r  <= sv3_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.vertex_index = o_idx_r;
  assign out_ch.corner       = o_cor_r;
  assign out_ch.pos_x        = o_px_r;
  assign out_ch.pos_y        = o_py_r;
  assign out_ch.pos_z        = o_pz_r;
  assign out_ch.norm_x       = o_nx_r;
  assign out_ch.norm_y       = o_ny_r;
  assign out_ch.norm_z       = o_nz_r;
  assign out_ch.bad_index    = o_bad_r;
  assign out_ch.last         = (o_cor_r == tqv_pkg::CORNER_BL);

endmodule

>>> src/tqv_checker.sv
// Port-level assertions of the torus quad vertex generator and their binding.
module tqv_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [17:0]          vertex_index,
  input logic [1:0]           corner,
  input logic signed [15:0]   norm_z,
  input logic                 last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(vertex_index))
    else $error("stalled vertex word changed");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (last == (corner == tqv_pkg::CORNER_BL)))
    else $error("last flag does not match corner");

  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (vertex_index[1:0] == corner))
    else $error("vertex slot does not match corner");

  a_norm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (norm_z <= 16'sd16384) && (norm_z >= -16'sd16384))
    else $error("normal component out of unit range");

endmodule

bind torus_quad_vertex_generator tqv_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .vertex_index(out_ch.vertex_index), .corner(out_ch.corner),
  .norm_z(out_ch.norm_z), .last(out_ch.last)
);

>>> test/tqv_checker.sv
// Scoreboard for the torus quad vertex generator: predicts every vertex word and compares.
module tqv_scoreboard (
  input  logic clk,
  input  logic rst_n,
  tqv_in_if    in_ch,
  tqv_out_if   out_ch,
  tqv_cfg_if   cfg_ch,
  output int   fails,
  output int   pending,
  output int   cells,
  output int   vertices
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STEP_CAP = 256;

  typedef struct packed {
    logic [17:0]        vertex_index;
    logic [1:0]         corner;
    logic signed [17:0] pos_x;
    logic signed [17:0] pos_y;
    logic signed [17:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic               bad_index;
    logic               last;
  } vertex_t;

  const longint ARC_TURN [16] = '{2097152, 1238021, 654136, 332050, 166669, 83416,
                                  41718, 20860, 10430, 5215, 2608, 1304, 652, 326,
                                  163, 81};

  logic [15:0] major_r;
  logic [15:0] minor_r;
  logic [8:0]  step_req;
  vertex_t     vertex_q[$];
  int          mismatches;

  assign pending = vertex_q.size();

  function automatic longint rnd_shift(input longint v, input int k);
    return (v + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void cos_sin_q14(input longint unsigned a, input longint unsigned n,
                                      output longint c, output longint s);
    longint unsigned am;
    longint unsigned ph;
    int              quad;
    longint          x;
    longint          y;
    longint          z;
    longint          dx;
    longint          dy;
    longint          cc;
    longint          ss;
    am = a % n;
    ph = (((am << 24) + n / 2) / n) & 64'hFFFFFF;
    quad = int'(ph >> 22);
    z = longint'(ph & 64'h3FFFFF);
    x = 652032874;
    y = 0;
    for (int k = 0; k < 16; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARC_TURN[k];
      end else begin
        x += dx; y -= dy; z += ARC_TURN[k];
      end
    end
    case (quad)
      0:       begin cc = x;  ss = y;  end
      1:       begin cc = -y; ss = x;  end
      2:       begin cc = -x; ss = -y; end
      default: begin cc = y;  ss = -x; end
    endcase
    c = clip(rnd_shift(cc, 16), -16384, 16384);
    s = clip(rnd_shift(ss, 16), -16384, 16384);
  endfunction

  function automatic string show(input vertex_t v);
    return $sformatf("idx=%0d c=%0d pos=(%0d,%0d,%0d) n=(%0d,%0d,%0d) bad=%0b last=%0b",
                     v.vertex_index, v.corner, v.pos_x, v.pos_y, v.pos_z,
                     v.norm_x, v.norm_y, v.norm_z, v.bad_index, v.last);
  endfunction

  task automatic push_cell_vertices(input logic [7:0] ri, input logic [7:0] si);
    longint unsigned n;
    longint unsigned a;
    longint unsigned b;
    longint          cu;
    longint          su;
    longint          cv;
    longint          sv;
    longint          ring;
    vertex_t         v;
    n = step_req < 8 ? 8 : (step_req > STEP_CAP ? STEP_CAP : step_req);
    for (int c = 0; c < 4; c++) begin
      a = ri + ((c == tqv_pkg::CORNER_TR || c == tqv_pkg::CORNER_BR) ? 1 : 0);
      b = si + ((c >= tqv_pkg::CORNER_BR) ? 1 : 0);
      cos_sin_q14(a, n, cu, su);
      cos_sin_q14(b, n, cv, sv);
      ring = longint'(major_r) * 16384 + longint'(minor_r) * cv;
      v.vertex_index = 18'((longint'(ri) * n + si) * 4 + c);
      v.corner       = 2'(c);
      v.pos_x        = 18'(clip(rnd_shift(ring * cu, 28), -131072, 131071));
      v.pos_y        = 18'(clip(rnd_shift(ring * su, 28), -131072, 131071));
      v.pos_z        = 18'(clip(rnd_shift(longint'(minor_r) * sv, 14), -131072, 131071));
      v.norm_x       = 16'(rnd_shift(cv * cu, 14));
      v.norm_y       = 16'(rnd_shift(cv * su, 14));
      v.norm_z       = 16'(sv);
      v.bad_index    = (ri >= n) || (si >= n);
      v.last         = (c == tqv_pkg::CORNER_BL);
      vertex_q.push_back(v);
    end
  endtask

  always @(posedge clk) begin
    vertex_t got;
    vertex_t exp_v;
    if (!rst_n) begin
      major_r  <= 16'd256;
      minor_r  <= 16'd64;
      step_req <= 9'd8;
      vertex_q.delete();
      fails <= 0;
      mismatches = 0;
      cells <= 0;
      vertices <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          tqv_pkg::REG_MAJOR: major_r  <= cfg_ch.data;
          tqv_pkg::REG_MINOR: minor_r  <= cfg_ch.data;
          tqv_pkg::REG_STEPS: step_req <= cfg_ch.data[8:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        push_cell_vertices(in_ch.ring_index, in_ch.segment_index);
        cells <= cells + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.vertex_index, out_ch.corner, out_ch.pos_x, out_ch.pos_y,
                out_ch.pos_z, out_ch.norm_x, out_ch.norm_y, out_ch.norm_z,
                out_ch.bad_index, out_ch.last};
        vertices <= vertices + 1;
        if (vertex_q.size() == 0) begin
          mismatches++;
          fails <= fails + 1;
          if (mismatches <= 10) $display("unexpected vertex word: %s", show(got));
        end else begin
          exp_v = vertex_q.pop_front();
          if (got != exp_v) begin
            mismatches++;
            fails <= fails + 1;
            if (mismatches <= 10) begin
              $display("vertex mismatch at %0t", $time);
              $display("  expected %s", show(exp_v));
              $display("  actual   %s", show(got));
            end
          end
        end
      end
    end
  end

endmodule

>>> test/tb_top.sv
// Stimulus and verdict for the torus quad vertex generator.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [tqv_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fails;
  int   pending;
  int   cells;
  int   vertices;
  bit   calm = 1'b0;
  bit   held = 1'b0;

  tqv_in_if  in_ch();
  tqv_out_if out_ch();
  tqv_cfg_if cfg_ch();

  torus_quad_vertex_generator #(.MAX_STEPS(256)) DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  tqv_scoreboard checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fails(fails), .pending(pending), .cells(cells), .vertices(vertices)
  );

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("torus_quad_vertex_generator verification failed");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_cell(input logic [7:0] ri, input logic [7:0] si);
    int g;
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.ring_index    <= ri;
    in_ch.segment_index <= si;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [tqv_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_cells(input int count, input int n);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) == 0)
        send_cell(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      else
        send_cell(8'($urandom_range(0, n - 1)), 8'($urandom_range(0, n - 1)));
    end
  endtask

  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!held && cells >= 120) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (300) @(negedge clk);
      end else if (!calm && $urandom_range(0, 199) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(20, 60)) @(negedge clk);
      end else begin
        out_ch.ready <= calm || ($urandom_range(0, 99) < 70);
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.ring_index = '0;
    in_ch.segment_index = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_cell(8'd0, 8'd0);
    send_cell(8'd7, 8'd7);
    send_cell(8'd3, 8'd5);
    send_cell(8'd8, 8'd0);
    send_cell(8'd0, 8'd8);
    send_cell(8'd255, 8'd255);
    send_cell(8'd255, 8'd0);
    send_cell(8'd170, 8'd85);
    random_cells(50, 8);
    settle();

    write_reg(tqv_pkg::REG_MAJOR, 16'd0);
    write_reg(tqv_pkg::REG_MINOR, 16'd1);
    write_reg(tqv_pkg::REG_STEPS, 16'd0);
    write_reg(REG_SPARE, 16'hFFFF);
    send_cell(8'd0, 8'd2);
    send_cell(8'd6, 8'd7);
    random_cells(40, 8);
    settle();

    write_reg(tqv_pkg::REG_MAJOR, 16'hFFFF);
    write_reg(tqv_pkg::REG_MINOR, 16'hFFFF);
    write_reg(tqv_pkg::REG_STEPS, 16'd256);
    send_cell(8'd255, 8'd255);
    send_cell(8'd0, 8'd64);
    send_cell(8'd64, 8'd192);
    calm = 1'b1;
    random_cells(60, 256);
    calm = 1'b0;
    settle();

    write_reg(tqv_pkg::REG_MINOR, 16'd0);
    write_reg(tqv_pkg::REG_STEPS, 16'd300);
    write_reg(tqv_pkg::REG_MAJOR, 16'd1000);
    send_cell(8'd255, 8'd254);
    random_cells(60, 256);
    settle();

    write_reg(tqv_pkg::REG_STEPS, 16'd7);
    write_reg(tqv_pkg::REG_MINOR, 16'd200);
    write_reg(tqv_pkg::REG_MAJOR, 16'd900);
    random_cells(50, 8);
    settle();

    write_reg(tqv_pkg::REG_STEPS, 16'd13);
    write_reg(tqv_pkg::REG_MAJOR, 16'($urandom_range(0, 65535)));
    write_reg(tqv_pkg::REG_MINOR, 16'($urandom_range(1, 65535)));
    send_cell(8'd12, 8'd12);
    send_cell(8'd13, 8'd3);
    random_cells(60, 13);
    settle();

    write_reg(tqv_pkg::REG_STEPS, 16'hFE64);
    write_reg(tqv_pkg::REG_MAJOR, 16'd3000);
    write_reg(tqv_pkg::REG_MINOR, 16'd700);
    random_cells(110, 100);
    settle();

    repeat (30) @(negedge clk);
    $display("covered %0d cells and %0d vertex words over seven register settings,", cells,
             vertices);
    $display("including step floors and ceilings, out-of-range cells and zero tube radius");
    if (fails == 0 && pending == 0) begin
      $display("torus_quad_vertex_generator verification clean");
    end else begin
      $display("torus_quad_vertex_generator verification failed");
    end
    $finish;
  end

endmodule
